/* hw/rtl/rotate_project_point_assert.svh */
`ifndef ROTATE_PROJECT_POINT_ASSERT_SVH
`define ROTATE_PROJECT_POINT_ASSERT_SVH

// check cons in the same cycle as ante
`define RPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define RPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rpp_pkg.sv */
package rpp_pkg;

    localparam int PT_W       = 11;
    localparam int COS_W      = 16;
    localparam int DIM_W      = 12;
    localparam int PITCH_W    = 14;
    localparam int SCR_W      = 16;
    localparam int ADDR_W     = 26;
    localparam int QUO_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PIX_SHIFT  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_COS   = 3'd0,
        CFG_ROT_SIN   = 3'd1,
        CFG_ROT_EN    = 3'd2,
        CFG_VIEW_DIST = 3'd3,
        CFG_SCR_W     = 3'd4,
        CFG_SCR_H     = 3'd5,
        CFG_PITCH     = 3'd6
    } cfg_reg_t;

    localparam logic signed [COS_W-1:0] ROT_COS_RST   = 16'sd16384;
    localparam logic signed [COS_W-1:0] ROT_SIN_RST   = 16'sd0;
    localparam logic                    ROT_EN_RST    = 1'b1;
    localparam logic [DIM_W-1:0]        VIEW_DIST_RST = 12'd300;
    localparam logic [DIM_W-1:0]        SCR_W_RST     = 12'd640;
    localparam logic [DIM_W-1:0]        SCR_H_RST     = 12'd580;
    localparam logic [PITCH_W-1:0]      PITCH_RST     = 14'd2560;

    localparam logic signed [SCR_W-1:0] SAT_MAX     = 16'sh7FFF;
    localparam logic signed [SCR_W-1:0] SAT_MIN     = 16'sh8000;
    localparam logic [QUO_W-1:0]        SAT_NEG_LIM = 16'h8000;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic den_pos;
    } div_flags_t;

    function automatic logic signed [SCR_W-1:0] sat_quotient(
        input logic [QUO_W-1:0] q,
        input logic             neg,
        input logic             ovf
    );
        logic signed [SCR_W-1:0] r;
        if (!neg)
        begin
            r = (ovf || q[QUO_W-1]) ? SAT_MAX : $signed(q);
        end
        else
        begin
            r = (ovf || (q > SAT_NEG_LIM)) ? SAT_MIN : $signed(-q);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/rotate_project_point.sv */
// Rotate a model point about the y axis and project it onto the frame buffer.
// Input channel: in_valid/in_ready with point_x, point_y, point_z (11-bit signed).
// Output channel: out_valid/out_ready with screen_x, screen_y (16-bit signed,
// saturated), visible and byte_address (row*pitch + col*4, zero when not visible).
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while no transaction is in flight.
// Throughput: one transaction per cycle while no result waits on out_ready. The
// 25 register stages are set mainly by the restoring divider, which retires one
// quotient bit per stage for each axis.
// Reset clears all stage valid bits and loads the register defaults
// (cos 1.0, sin 0, rotation on, distance 300, 640x580 frame, pitch 2560).
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated. in_ready stays high while the
// output stage is empty or being taken, independent of items still in flight.
module rotate_project_point #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [rpp_pkg::PT_W-1:0]       point_x,
    input  logic signed [rpp_pkg::PT_W-1:0]       point_y,
    input  logic signed [rpp_pkg::PT_W-1:0]       point_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [rpp_pkg::SCR_W-1:0]      screen_x,
    output logic signed [rpp_pkg::SCR_W-1:0]      screen_y,
    output logic                                  visible,
    output logic [rpp_pkg::ADDR_W-1:0]            byte_address,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rpp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int PT_W  = rpp_pkg::PT_W;
    localparam int COS_W = rpp_pkg::COS_W;
    localparam int DIM_W = rpp_pkg::DIM_W;
    localparam int SCR_W = rpp_pkg::SCR_W;
    localparam int QW    = rpp_pkg::QUO_W;
    localparam int PW    = PT_W + COS_W;
    localparam int XW    = (FRAC_BITS + PT_W > PW + 1) ? FRAC_BITS + PT_W : PW + 1;
    localparam int DW    = ((XW > FRAC_BITS + DIM_W + 1) ? XW : FRAC_BITS + DIM_W + 1) + 1;
    localparam int CW    = DIM_W;
    localparam int MW    = DW + CW;
    localparam int LW    = XW + DIM_W + 1;
    localparam int NW    = ((MW > LW) ? MW : LW) + 1;
    localparam int RW    = (NW > DW + QW) ? NW : DW + QW;
    localparam int NDIV  = QW;

    logic signed [COS_W-1:0]           rotation_cos_reg;
    logic signed [COS_W-1:0]           rotation_sin_reg;
    logic                              rotate_enable_reg;
    logic [DIM_W-1:0]                  view_distance_reg;
    logic [DIM_W-1:0]                  screen_width_reg;
    logic [DIM_W-1:0]                  screen_height_reg;
    logic [rpp_pkg::PITCH_W-1:0]       row_pitch_reg;

    logic adv;

    logic                    s1_vld_reg;
    logic signed [PT_W-1:0]  s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [PW-1:0]    s1_xc_reg, s1_zs_reg, s1_zc_reg, s1_xs_reg;
    logic signed [PW-1:0]    s1_xc_next, s1_zs_next, s1_zc_next, s1_xs_next;

    logic                    s2_vld_reg;
    logic signed [XW-1:0]    s2_xs_reg, s2_ys_reg, s2_zs_reg;
    logic signed [XW-1:0]    s2_xs_next, s2_ys_next, s2_zs_next;

    logic                    s3_vld_reg;
    logic signed [XW-1:0]    s3_xs_reg, s3_ys_reg;
    logic signed [DW-1:0]    s3_den_reg, s3_den_next;

    logic signed [CW-1:0]    cx_s, cy_s;
    logic signed [DIM_W:0]   dist_s;

    logic                    s4_vld_reg;
    logic signed [MW-1:0]    s4_cxd_reg, s4_cyd_reg, s4_cxd_next, s4_cyd_next;
    logic signed [LW-1:0]    s4_xd_reg, s4_yd_reg, s4_xd_next, s4_yd_next;
    logic [DW-2:0]           s4_den_reg;
    logic                    s4_den_pos_reg, s4_den_pos_next;

    logic                    s5_vld_reg;
    logic signed [NW-1:0]    s5_numx_reg, s5_numy_reg, s5_numx_next, s5_numy_next;
    logic [DW-2:0]           s5_den_reg;
    logic                    s5_den_pos_reg;

    logic signed [RW:0]      s5_lim, s5_numx_ext, s5_numy_ext;
    logic [NW-1:0]           s5_absx, s5_absy;
    rpp_pkg::div_flags_t     dv_flags_next;

    logic                    dv_vld_reg   [0:NDIV];
    rpp_pkg::div_flags_t     dv_flags_reg [0:NDIV];
    logic [DW-2:0]           dv_den_reg   [0:NDIV];
    logic [RW-1:0]           remx_reg     [0:NDIV];
    logic [RW-1:0]           remy_reg     [0:NDIV];
    logic [QW-1:0]           qx_reg       [0:NDIV];
    logic [QW-1:0]           qy_reg       [0:NDIV];

    logic                    s23_vld_reg;
    logic signed [SCR_W-1:0] s23_sx_reg, s23_sy_reg, s23_sx_next, s23_sy_next;
    logic                    s23_vis_reg, s23_vis_next;

    logic                    s24_vld_reg;
    logic signed [SCR_W-1:0] s24_sx_reg, s24_sy_reg;
    logic                    s24_vis_reg;
    logic [rpp_pkg::ADDR_W-1:0] s24_row_reg, s24_row_next;

    logic                    s25_vld_reg;
    logic signed [SCR_W-1:0] s25_sx_reg, s25_sy_reg;
    logic                    s25_vis_reg;
    logic [rpp_pkg::ADDR_W-1:0] s25_addr_reg, s25_addr_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_cos_reg  <= rpp_pkg::ROT_COS_RST;
            rotation_sin_reg  <= rpp_pkg::ROT_SIN_RST;
            rotate_enable_reg <= rpp_pkg::ROT_EN_RST;
            view_distance_reg <= rpp_pkg::VIEW_DIST_RST;
            screen_width_reg  <= rpp_pkg::SCR_W_RST;
            screen_height_reg <= rpp_pkg::SCR_H_RST;
            row_pitch_reg     <= rpp_pkg::PITCH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rpp_pkg::CFG_ROT_COS:   rotation_cos_reg  <= cfg_data[COS_W-1:0];
                rpp_pkg::CFG_ROT_SIN:   rotation_sin_reg  <= cfg_data[COS_W-1:0];
                rpp_pkg::CFG_ROT_EN:    rotate_enable_reg <= cfg_data[0];
                rpp_pkg::CFG_VIEW_DIST: view_distance_reg <= cfg_data[DIM_W-1:0];
                rpp_pkg::CFG_SCR_W:     screen_width_reg  <= cfg_data[DIM_W-1:0];
                rpp_pkg::CFG_SCR_H:     screen_height_reg <= cfg_data[DIM_W-1:0];
                rpp_pkg::CFG_PITCH:     row_pitch_reg     <= cfg_data[rpp_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // advance every stage together unless a finished result is held
    assign adv      = !s25_vld_reg || out_ready;
    assign in_ready = adv;

    assign s1_xc_next = PW'(point_x) * PW'(rotation_cos_reg);
    assign s1_zs_next = PW'(point_z) * PW'(rotation_sin_reg);
    assign s1_zc_next = PW'(point_z) * PW'(rotation_cos_reg);
    assign s1_xs_next = PW'(point_x) * PW'(rotation_sin_reg);

    assign s2_xs_next = rotate_enable_reg ? XW'(s1_xc_reg) + XW'(s1_zs_reg)
                                          : XW'(s1_x_reg) <<< FRAC_BITS;
    assign s2_zs_next = rotate_enable_reg ? XW'(s1_zc_reg) - XW'(s1_xs_reg)
                                          : XW'(s1_z_reg) <<< FRAC_BITS;
    assign s2_ys_next = XW'(s1_y_reg) <<< FRAC_BITS;

    assign s3_den_next = $signed(DW'(view_distance_reg) << FRAC_BITS) + DW'(s2_zs_reg);

    assign cx_s   = $signed({1'b0, screen_width_reg[DIM_W-1:1]});
    assign cy_s   = $signed({1'b0, screen_height_reg[DIM_W-1:1]});
    assign dist_s = $signed({1'b0, view_distance_reg});

    assign s4_cxd_next     = MW'(s3_den_reg) * MW'(cx_s);
    assign s4_cyd_next     = MW'(s3_den_reg) * MW'(cy_s);
    assign s4_xd_next      = LW'(s3_xs_reg) * LW'(dist_s);
    assign s4_yd_next      = LW'(s3_ys_reg) * LW'(dist_s);
    assign s4_den_pos_next = !s3_den_reg[DW-1] && (s3_den_reg != '0);

    assign s5_numx_next = NW'(s4_cxd_reg) + NW'(s4_xd_reg);
    assign s5_numy_next = NW'(s4_cyd_reg) + NW'(s4_yd_reg);

    assign s5_lim      = $signed({1'b0, RW'(s5_den_reg) << QW});
    assign s5_numx_ext = (RW+1)'(s5_numx_reg);
    assign s5_numy_ext = (RW+1)'(s5_numy_reg);
    assign s5_absx     = s5_numx_reg[NW-1] ? NW'(-s5_numx_reg) : NW'(s5_numx_reg);
    assign s5_absy     = s5_numy_reg[NW-1] ? NW'(-s5_numy_reg) : NW'(s5_numy_reg);

    always_comb
    begin
        dv_flags_next.neg_x   = s5_numx_reg[NW-1];
        dv_flags_next.neg_y   = s5_numy_reg[NW-1];
        dv_flags_next.ovf_x   = s5_numx_reg[NW-1] ? (s5_numx_ext <= -s5_lim)
                                                  : (s5_numx_ext >= s5_lim);
        dv_flags_next.ovf_y   = s5_numy_reg[NW-1] ? (s5_numy_ext <= -s5_lim)
                                                  : (s5_numy_ext >= s5_lim);
        dv_flags_next.den_pos = s5_den_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            s23_vld_reg   <= 1'b0;
            s24_vld_reg   <= 1'b0;
            s25_vld_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            dv_vld_reg[0] <= s5_vld_reg;
            s23_vld_reg   <= dv_vld_reg[NDIV];
            s24_vld_reg   <= s23_vld_reg;
            s25_vld_reg   <= s24_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg  <= point_x;
            s1_y_reg  <= point_y;
            s1_z_reg  <= point_z;
            s1_xc_reg <= s1_xc_next;
            s1_zs_reg <= s1_zs_next;
            s1_zc_reg <= s1_zc_next;
            s1_xs_reg <= s1_xs_next;

            s2_xs_reg <= s2_xs_next;
            s2_ys_reg <= s2_ys_next;
            s2_zs_reg <= s2_zs_next;

            s3_xs_reg  <= s2_xs_reg;
            s3_ys_reg  <= s2_ys_reg;
            s3_den_reg <= s3_den_next;

            s4_cxd_reg     <= s4_cxd_next;
            s4_cyd_reg     <= s4_cyd_next;
            s4_xd_reg      <= s4_xd_next;
            s4_yd_reg      <= s4_yd_next;
            s4_den_reg     <= s3_den_reg[DW-2:0];
            s4_den_pos_reg <= s4_den_pos_next;

            s5_numx_reg    <= s5_numx_next;
            s5_numy_reg    <= s5_numy_next;
            s5_den_reg     <= s4_den_reg;
            s5_den_pos_reg <= s4_den_pos_reg;

            dv_flags_reg[0] <= dv_flags_next;
            dv_den_reg[0]   <= s5_den_reg;
            remx_reg[0]     <= RW'(s5_absx);
            remy_reg[0]     <= RW'(s5_absy);
            qx_reg[0]       <= '0;
            qy_reg[0]       <= '0;

            s23_sx_reg  <= s23_sx_next;
            s23_sy_reg  <= s23_sy_next;
            s23_vis_reg <= s23_vis_next;

            s24_sx_reg  <= s23_sx_reg;
            s24_sy_reg  <= s23_sy_reg;
            s24_vis_reg <= s23_vis_reg;
            s24_row_reg <= s24_row_next;

            s25_sx_reg   <= s24_sx_reg;
            s25_sy_reg   <= s24_sy_reg;
            s25_vis_reg  <= s24_vis_reg;
            s25_addr_reg <= s25_addr_next;
        end
    end

    // restoring divide, most significant quotient bit first
    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        localparam int B = NDIV - 1 - k;

        logic [RW-1:0] dsh;
        logic [RW:0]   dfx;
        logic [RW:0]   dfy;

        assign dsh = RW'(dv_den_reg[k]) << B;
        assign dfx = {1'b0, remx_reg[k]} - {1'b0, dsh};
        assign dfy = {1'b0, remy_reg[k]} - {1'b0, dsh};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_flags_reg[k+1] <= dv_flags_reg[k];
                dv_den_reg[k+1]   <= dv_den_reg[k];
                remx_reg[k+1]     <= dfx[RW] ? remx_reg[k] : dfx[RW-1:0];
                remy_reg[k+1]     <= dfy[RW] ? remy_reg[k] : dfy[RW-1:0];
                qx_reg[k+1]       <= {qx_reg[k][QW-2:0], ~dfx[RW]};
                qy_reg[k+1]       <= {qy_reg[k][QW-2:0], ~dfy[RW]};
            end
        end
    end

    always_comb
    begin
        if (dv_flags_reg[NDIV].den_pos)
        begin
            s23_sx_next = rpp_pkg::sat_quotient(qx_reg[NDIV], dv_flags_reg[NDIV].neg_x,
                                                dv_flags_reg[NDIV].ovf_x);
            s23_sy_next = rpp_pkg::sat_quotient(qy_reg[NDIV], dv_flags_reg[NDIV].neg_y,
                                                dv_flags_reg[NDIV].ovf_y);
        end
        else
        begin
            s23_sx_next = '0;
            s23_sy_next = '0;
        end
        s23_vis_next = dv_flags_reg[NDIV].den_pos
                    && !s23_sx_next[SCR_W-1] && !s23_sy_next[SCR_W-1]
                    && ($unsigned(s23_sx_next) < SCR_W'(screen_width_reg))
                    && ($unsigned(s23_sy_next) < SCR_W'(screen_height_reg));
    end

    assign s24_row_next = rpp_pkg::ADDR_W'(s23_sy_reg[DIM_W-1:0])
                        * rpp_pkg::ADDR_W'(row_pitch_reg);

    assign s25_addr_next = s24_vis_reg
        ? s24_row_reg + (rpp_pkg::ADDR_W'(s24_sx_reg[DIM_W-1:0]) << rpp_pkg::PIX_SHIFT)
        : '0;

    assign out_valid    = s25_vld_reg;
    assign screen_x     = s25_sx_reg;
    assign screen_y     = s25_sy_reg;
    assign visible      = s25_vis_reg;
    assign byte_address = s25_addr_reg;

endmodule

/* hw/rtl/rpp_checker.sv */
`include "rotate_project_point_assert.svh"

module rpp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [rpp_pkg::SCR_W-1:0]   screen_x,
    input logic signed [rpp_pkg::SCR_W-1:0]   screen_y,
    input logic                               visible,
    input logic [rpp_pkg::ADDR_W-1:0]         byte_address
);

    `RPP_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")

    `RPP_ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(screen_x) && $stable(screen_y) && $stable(visible) && $stable(byte_address), "result changed while stalled")

    `RPP_ASSERT_NOW(a_hidden_addr_zero, out_valid && !visible, byte_address == '0, "address set for hidden point")

    `RPP_ASSERT_NOW(a_visible_nonneg, out_valid && visible, !screen_x[rpp_pkg::SCR_W-1] && !screen_y[rpp_pkg::SCR_W-1], "visible point with negative coordinate")

endmodule

bind rotate_project_point rpp_checker u_rpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .visible      (visible),
    .byte_address (byte_address)
);
